// ----- rtl/wnhs_pkg.sv -----
// Shared types, codes and defaults for the weighted next-hop select unit.
package wnhs_pkg;

    localparam int unsigned ENTRIES_DEFAULT       = 16;
    localparam int unsigned GRADIENT_BITS_DEFAULT = 16;
    localparam int unsigned RANDOM_BITS_DEFAULT   = 16;

    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned VALUE_W  = 16;

    localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SELECT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHOSEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_LATCH,
        S_MUL,
        S_MATCH,
        S_FINISH
    } wnhs_state_t;

    typedef struct packed {
        logic wr_en;
        logic rm_en;
        logic match_mode;
        logic unit_weight;
    } cell_ctl_t;

endpackage

// ----- rtl/wnhs_cell.sv -----
// One table entry of the chain: stores a gradient and valid bit, passes sums to the next cell.
module wnhs_cell #(
    parameter int unsigned ENTRIES       = wnhs_pkg::ENTRIES_DEFAULT,
    parameter int unsigned GRADIENT_BITS = wnhs_pkg::GRADIENT_BITS_DEFAULT,
    parameter int unsigned INDEX         = 0,
    localparam int unsigned AW = GRADIENT_BITS + $clog2(ENTRIES),
    localparam int unsigned CW = $clog2(ENTRIES + 1),
    localparam int unsigned IW = $clog2(ENTRIES)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wnhs_pkg::cell_ctl_t               ctl,
    input  logic [wnhs_pkg::INDEX_W-1:0]      entry_index,
    input  logic [wnhs_pkg::VALUE_W-1:0]      gradient_value,
    input  logic [AW-1:0]                     target,
    input  logic [AW-1:0]                     sum_in,
    input  logic [CW-1:0]                     cnt_in,
    input  logic                              hit_in,
    input  logic [IW-1:0]                     idx_in,
    output logic [AW-1:0]                     sum_out,
    output logic [CW-1:0]                     cnt_out,
    output logic                              hit_out,
    output logic [IW-1:0]                     idx_out
);
    import wnhs_pkg::*;

    localparam logic [IW-1:0] OWN_IDX = IW'(INDEX);

    logic [GRADIENT_BITS-1:0]          gradient_reg;
    logic                              valid_reg;
    logic [AW-1:0]                     sum_reg;
    logic [CW-1:0]                     cnt_reg;
    logic                              hit_reg;
    logic [IW-1:0]                     idx_reg;

    logic [VALUE_W+GRADIENT_BITS-1:0]  grad_ext;
    logic                              addressed;
    logic [AW-1:0]                     weight;
    logic [AW-1:0]                     sum_next;
    logic [CW-1:0]                     cnt_next;
    logic                              hit_next;
    logic [IW-1:0]                     idx_next;

    assign grad_ext  = {{GRADIENT_BITS{1'b0}}, gradient_value};
    assign addressed = ({{(32-INDEX_W){1'b0}}, entry_index} == 32'(INDEX));

    always_comb
    begin
        if (ctl.match_mode && ctl.unit_weight)
        begin
            weight = AW'(1);
        end
        else
        begin
            weight = AW'(gradient_reg);
        end
        sum_next = sum_in + (valid_reg ? weight : '0);
        cnt_next = cnt_in + CW'(valid_reg);
        hit_next = hit_in || (ctl.match_mode && valid_reg && (target < sum_next));
        idx_next = hit_in ? idx_in : OWN_IDX;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && addressed)
        begin
            gradient_reg <= grad_ext[GRADIENT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (ctl.wr_en && addressed)
            begin
                valid_reg <= 1'b1;
            end
            else if (ctl.rm_en && addressed)
            begin
                valid_reg <= 1'b0;
            end
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            hit_reg <= hit_next;
            idx_reg <= idx_next;
        end
    end

    assign sum_out = sum_reg;
    assign cnt_out = cnt_reg;
    assign hit_out = hit_reg;
    assign idx_out = idx_reg;

endmodule

// ----- rtl/wnhs_ctrl.sv -----
// Sequencer: handshake, chain passes, bit-serial scaling of the random value, result register.
module wnhs_ctrl #(
    parameter int unsigned ENTRIES       = wnhs_pkg::ENTRIES_DEFAULT,
    parameter int unsigned GRADIENT_BITS = wnhs_pkg::GRADIENT_BITS_DEFAULT,
    parameter int unsigned RANDOM_BITS   = wnhs_pkg::RANDOM_BITS_DEFAULT,
    localparam int unsigned AW = GRADIENT_BITS + $clog2(ENTRIES),
    localparam int unsigned CW = $clog2(ENTRIES + 1),
    localparam int unsigned IW = $clog2(ENTRIES)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wnhs_pkg::OPCODE_W-1:0]     opcode,
    input  logic [wnhs_pkg::VALUE_W-1:0]      random_fraction,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wnhs_pkg::STATUS_W-1:0]     status,
    output logic [wnhs_pkg::INDEX_W-1:0]      chosen_index,
    output wnhs_pkg::cell_ctl_t               ctl,
    output logic [AW-1:0]                     target,
    input  logic [AW-1:0]                     sum_tail,
    input  logic [CW-1:0]                     cnt_tail,
    input  logic                              hit_tail,
    input  logic [IW-1:0]                     idx_tail
);
    import wnhs_pkg::*;

    localparam int unsigned PW = AW + RANDOM_BITS;
    localparam int unsigned SPAN = (ENTRIES > RANDOM_BITS) ? ENTRIES : RANDOM_BITS;
    localparam int unsigned SW = $clog2(SPAN);
    localparam logic [SW-1:0] STEP_CHAIN = SW'(ENTRIES - 1);
    localparam logic [SW-1:0] STEP_MUL   = SW'(RANDOM_BITS - 1);

    wnhs_state_t                       state_reg, state_next;
    logic [SW-1:0]                     step_reg, step_next;
    logic [RANDOM_BITS-1:0]            rnd_reg, rnd_next;
    logic [AW-1:0]                     mult_reg, mult_next;
    logic [PW-1:0]                     prod_reg, prod_next;
    logic                              unit_reg, unit_next;
    logic                              none_reg, none_next;
    logic                              out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]               status_reg, status_next;
    logic [INDEX_W-1:0]                chosen_reg, chosen_next;

    logic [VALUE_W+RANDOM_BITS-1:0]    rnd_ext;
    logic [IW+INDEX_W-1:0]             idx_ext;
    logic                              out_free;
    logic                              accept;

    assign rnd_ext  = {{RANDOM_BITS{1'b0}}, random_fraction};
    assign idx_ext  = {{INDEX_W{1'b0}}, idx_tail};
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && (state_reg == S_IDLE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rnd_next       = rnd_reg;
        mult_next      = mult_reg;
        prod_next      = prod_reg;
        unit_next      = unit_reg;
        none_next      = none_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        chosen_next    = chosen_reg;
        in_stall       = 1'b1;
        ctl            = '0;
        ctl.unit_weight = unit_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_stall   = !out_free;
                ctl.wr_en  = accept && (opcode == OP_WRITE);
                ctl.rm_en  = accept && (opcode == OP_REMOVE);
                if (accept)
                begin
                    if (opcode[1])
                    begin
                        rnd_next   = rnd_ext[RANDOM_BITS-1:0];
                        step_next  = '0;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        status_next    = (opcode == OP_WRITE) ? ST_WRITTEN : ST_REMOVED;
                        chosen_next    = '0;
                    end
                end
            end
            S_SUM:
            begin
                step_next = step_reg + SW'(1);
                if (step_reg == STEP_CHAIN)
                begin
                    step_next  = '0;
                    state_next = S_LATCH;
                end
            end
            S_LATCH:
            begin
                mult_next  = (sum_tail != '0) ? sum_tail : AW'(cnt_tail);
                unit_next  = (sum_tail == '0);
                none_next  = (cnt_tail == '0);
                prod_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = {prod_reg[PW-2:0], 1'b0}
                          + (rnd_reg[RANDOM_BITS-1] ? PW'(mult_reg) : '0);
                rnd_next  = {rnd_reg[RANDOM_BITS-2:0], 1'b0};
                step_next = step_reg + SW'(1);
                if (step_reg == STEP_MUL)
                begin
                    step_next  = '0;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                ctl.match_mode = 1'b1;
                step_next      = step_reg + SW'(1);
                if (step_reg == STEP_CHAIN)
                begin
                    step_next  = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctl.match_mode = 1'b1;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (!none_reg && hit_tail)
                    begin
                        status_next = ST_CHOSEN;
                        chosen_next = idx_ext[INDEX_W-1:0];
                    end
                    else
                    begin
                        status_next = ST_NONE;
                        chosen_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg    <= rnd_next;
        mult_reg   <= mult_next;
        prod_reg   <= prod_next;
        unit_reg   <= unit_next;
        none_reg   <= none_next;
        status_reg <= status_next;
        chosen_reg <= chosen_next;
    end

    assign target       = prod_reg[PW-1:RANDOM_BITS];
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_index = chosen_reg;

endmodule

// ----- rtl/weighted_next_hop_select_unit.sv -----
// Top level of the weighted next-hop select unit: sequencer plus a chain of entry cells.
//
// Input channel (in_valid / in_stall) carries one item per transfer: opcode,
// entry_index, gradient_value, random_fraction. Output channel (out_valid /
// out_stall) returns one status / chosen_index transfer per item.
// Write and remove update the addressed cell at the input transfer and
// present their result in the next cycle.
// Select goes from input transfer to result through one pass down the
// cell chain to sum the valid gradients, a shift-add multiplier to scale
// the random value and one more pass down the chain to find the matching
// range.
// One item is in work at a time; the next input transfer is taken once the
// result register is free or being emptied: every cycle after a write or
// remove, and after a select once its result has been registered.
// Reset clears every valid mark and the result valid flag; gradients,
// status and chosen index are not cleared. While the receiver stalls, the
// result holds and no new input is taken.
module weighted_next_hop_select_unit #(
    parameter int unsigned ENTRIES       = wnhs_pkg::ENTRIES_DEFAULT,
    parameter int unsigned GRADIENT_BITS = wnhs_pkg::GRADIENT_BITS_DEFAULT,
    parameter int unsigned RANDOM_BITS   = wnhs_pkg::RANDOM_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wnhs_pkg::OPCODE_W-1:0]     opcode,
    input  logic [wnhs_pkg::INDEX_W-1:0]      entry_index,
    input  logic [wnhs_pkg::VALUE_W-1:0]      gradient_value,
    input  logic [wnhs_pkg::VALUE_W-1:0]      random_fraction,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wnhs_pkg::STATUS_W-1:0]     status,
    output logic [wnhs_pkg::INDEX_W-1:0]      chosen_index
);
    import wnhs_pkg::*;

    localparam int unsigned AW = GRADIENT_BITS + $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned IW = $clog2(ENTRIES);

    cell_ctl_t          ctl;
    logic [AW-1:0]      target;
    logic [AW-1:0]      sum_link [0:ENTRIES];
    logic [CW-1:0]      cnt_link [0:ENTRIES];
    logic               hit_link [0:ENTRIES];
    logic [IW-1:0]      idx_link [0:ENTRIES];

    assign sum_link[0] = '0;
    assign cnt_link[0] = '0;
    assign hit_link[0] = 1'b0;
    assign idx_link[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        wnhs_cell #(
            .ENTRIES       (ENTRIES),
            .GRADIENT_BITS (GRADIENT_BITS),
            .INDEX         (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .entry_index    (entry_index),
            .gradient_value (gradient_value),
            .target         (target),
            .sum_in         (sum_link[i]),
            .cnt_in         (cnt_link[i]),
            .hit_in         (hit_link[i]),
            .idx_in         (idx_link[i]),
            .sum_out        (sum_link[i+1]),
            .cnt_out        (cnt_link[i+1]),
            .hit_out        (hit_link[i+1]),
            .idx_out        (idx_link[i+1])
        );
    end

    wnhs_ctrl #(
        .ENTRIES       (ENTRIES),
        .GRADIENT_BITS (GRADIENT_BITS),
        .RANDOM_BITS   (RANDOM_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .chosen_index    (chosen_index),
        .ctl             (ctl),
        .target          (target),
        .sum_tail        (sum_link[ENTRIES]),
        .cnt_tail        (cnt_link[ENTRIES]),
        .hit_tail        (hit_link[ENTRIES]),
        .idx_tail        (idx_link[ENTRIES])
    );

    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_CHOSEN) |-> (chosen_index == '0))
        else $error("chosen_index nonzero without a chosen neighbor");

    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode[1] |=> in_stall && !ctl.wr_en && !ctl.rm_en)
        else $error("input taken while a select is in work");

    a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !opcode[1] |=> out_valid
            && (status == ST_WRITTEN || status == ST_REMOVED))
        else $error("write or remove gave no result in the next cycle");

endmodule
